// File: sv/isr_pkg.sv
// Shared types and constants for the interrupt subscription router.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package isr_pkg;

  // Default sizes of the subscription table and its stored fields.
  localparam int unsigned EntriesDef     = 16;
  localparam int unsigned ChannelBitsDef = 16;
  localparam int unsigned IrqBitsDef     = 10;

  // Fixed widths of the transaction fields.
  localparam int unsigned ReqW     = 2;
  localparam int unsigned IrqW     = 10;
  localparam int unsigned ChanW    = 16;
  localparam int unsigned HandleW  = 32;
  localparam int unsigned CountW   = 5;
  localparam int unsigned SeqW     = 64;

  // A handle holds the low generation bits above an 8-bit slot tag.
  localparam int unsigned GenBits = 24;
  localparam int unsigned TagBits = 8;

  localparam logic [HandleW-1:0] GenReset = HandleW'(1);
  localparam logic [CountW-1:0]  CountMax = '1;

  typedef enum logic [ReqW-1:0] {
    REQ_SUB   = 2'd0,
    REQ_UNSUB = 2'd1,
    REQ_PUB   = 2'd2,
    REQ_COUNT = 2'd3
  } req_e;

  // Request as it travels down the row of table cells.
  typedef struct packed {
    logic               valid;
    req_e               req;
    logic [IrqW-1:0]    irq;
    logic [ChanW-1:0]   chan;
    logic               ok;
    logic [HandleW-1:0] handle;
    logic               done;
    logic [CountW-1:0]  count;
    logic [HandleW-1:0] new_handle;
    logic               pend_valid;
    logic [ChanW-1:0]   pend_chan;
    logic [SeqW-1:0]    pend_seq;
  } pkt_t;

  // Delivery pushed out by a cell when a newer match replaces the held one.
  typedef struct packed {
    logic             valid;
    logic [ChanW-1:0] chan;
    logic [IrqW-1:0]  irq;
    logic [SeqW-1:0]  seq;
  } emit_t;

  typedef struct packed {
    logic               status;
    logic [HandleW-1:0] new_handle;
    logic [CountW-1:0]  match_count;
    logic [ChanW-1:0]   dest_channel;
    logic [IrqW-1:0]    event_irq;
    logic [SeqW-1:0]    event_sequence;
    logic               last;
  } rsp_t;

endpackage

`default_nettype wire

// File: sv/isr_if.sv
// Valid/ready channel interfaces for requests and results of the router.
// Depends on isr_pkg for the field widths.
`default_nettype none

interface isr_in_if;
  import isr_pkg::*;

  logic                valid;
  logic                ready;
  logic [ReqW-1:0]     req_type;
  logic [IrqW-1:0]     irq_line;
  logic [ChanW-1:0]    channel_id;
  logic                channel_ok;
  logic [HandleW-1:0]  sub_handle;

  modport source (
    output valid, req_type, irq_line, channel_id, channel_ok, sub_handle,
    input  ready
  );
  modport sink (
    input  valid, req_type, irq_line, channel_id, channel_ok, sub_handle,
    output ready
  );
endinterface

interface isr_out_if;
  import isr_pkg::*;

  logic                valid;
  logic                ready;
  logic                status;
  logic [HandleW-1:0]  new_handle;
  logic [CountW-1:0]   match_count;
  logic [ChanW-1:0]    dest_channel;
  logic [IrqW-1:0]     event_irq;
  logic [SeqW-1:0]     event_sequence;
  logic                last;

  modport source (
    output valid, status, new_handle, match_count, dest_channel, event_irq,
           event_sequence, last,
    input  ready
  );
  modport sink (
    input  valid, status, new_handle, match_count, dest_channel, event_irq,
           event_sequence, last,
    output ready
  );
endinterface

`default_nettype wire

// File: sv/isr_cell.sv
// One slot of the subscription table plus the request register in front of it.
// Depends on isr_pkg for the request and delivery types.
`default_nettype none

module isr_cell #(
  parameter int unsigned CHANNEL_BITS = isr_pkg::ChannelBitsDef,
  parameter int unsigned IRQ_BITS     = isr_pkg::IrqBitsDef,
  parameter int unsigned INDEX        = 0
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         advance_i,
  input  wire logic [isr_pkg::GenBits-1:0]  gen_i,
  input  wire isr_pkg::pkt_t                pkt_i,
  output isr_pkg::pkt_t                     pkt_o,
  output isr_pkg::emit_t                    emit_o
);
  import isr_pkg::*;

  localparam logic [TagBits-1:0] SlotTag = TagBits'(INDEX + 1);

  pkt_t                    pkt_q;
  logic [HandleW-1:0]      handle_q, handle_d;
  logic [IRQ_BITS-1:0]     irq_q, irq_d;
  logic [CHANNEL_BITS-1:0] chan_q, chan_d;
  logic [SeqW-1:0]         seq_q, seq_d;
  logic                    live;
  logic                    irq_hit;
  logic [SeqW-1:0]         seq_inc;

  assign live    = (handle_q != '0);
  assign irq_hit = live && (irq_q == IRQ_BITS'(pkt_q.irq));
  assign seq_inc = seq_q + SeqW'(1);

  always_comb begin
    pkt_o    = pkt_q;
    emit_o   = '0;
    handle_d = handle_q;
    irq_d    = irq_q;
    chan_d   = chan_q;
    seq_d    = seq_q;
    if (pkt_q.valid) begin
      unique case (pkt_q.req)
        REQ_SUB: begin
          if (pkt_q.ok && !pkt_q.done && !live) begin
            handle_d         = {gen_i, SlotTag};
            irq_d            = IRQ_BITS'(pkt_q.irq);
            chan_d           = CHANNEL_BITS'(pkt_q.chan);
            seq_d            = '0;
            pkt_o.done       = 1'b1;
            pkt_o.new_handle = {gen_i, SlotTag};
          end
        end
        REQ_UNSUB: begin
          if (!pkt_q.done && (pkt_q.handle != '0) && (handle_q == pkt_q.handle)) begin
            handle_d   = '0;
            irq_d      = '0;
            chan_d     = '0;
            seq_d      = '0;
            pkt_o.done = 1'b1;
          end
        end
        REQ_PUB: begin
          if (irq_hit) begin
            seq_d = seq_inc;
            // The held delivery is not the last one, so it leaves now.
            if (pkt_q.pend_valid) begin
              emit_o.valid = 1'b1;
              emit_o.chan  = pkt_q.pend_chan;
              emit_o.irq   = pkt_q.irq;
              emit_o.seq   = pkt_q.pend_seq;
            end
            pkt_o.pend_valid = 1'b1;
            pkt_o.pend_chan  = ChanW'(chan_q);
            pkt_o.pend_seq   = seq_inc;
          end
        end
        REQ_COUNT: begin
          if (irq_hit && (pkt_q.count != CountMax)) begin
            pkt_o.count = pkt_q.count + CountW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pkt_q    <= '0;
      handle_q <= '0;
      irq_q    <= '0;
      chan_q   <= '0;
      seq_q    <= '0;
    end else if (advance_i) begin
      pkt_q    <= pkt_i;
      handle_q <= handle_d;
      irq_q    <= irq_d;
      chan_q   <= chan_d;
      seq_q    <= seq_d;
    end
  end

endmodule

`default_nettype wire

// File: sv/interrupt_subscription_router_top.sv
// Top level of the interrupt subscription router: a row of table cells,
// a closing stage and the result register. Depends on isr_pkg, isr_if, isr_cell.
//
//   channel  dir  handshake     carries
//   req_i    in   valid/ready   req_type, irq_line, channel_id, channel_ok, sub_handle
//   rsp_o    out  valid/ready   status, new_handle, match_count, dest_channel,
//                               event_irq, event_sequence, last
//
// A request walks the row of ENTRIES cells, one cell per cycle while the row is not
// halted, then a closing stage; the next request is taken once the closing stage
// is done.
// Reset clears the whole table and sets the generation counter to one.
// When the result register is full and not taken, the row halts on any cycle
// that has a delivery to hand out, so nothing is dropped.
`default_nettype none

module interrupt_subscription_router_top #(
  parameter int unsigned ENTRIES      = isr_pkg::EntriesDef,
  parameter int unsigned CHANNEL_BITS = isr_pkg::ChannelBitsDef,
  parameter int unsigned IRQ_BITS     = isr_pkg::IrqBitsDef
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  isr_in_if.sink     req_i,
  isr_out_if.source  rsp_o
);
  import isr_pkg::*;

  pkt_t               chain [ENTRIES+1];
  pkt_t               chain_head;
  emit_t              cell_emit [ENTRIES];
  emit_t              cell_any;
  pkt_t               fin_q;
  logic               busy_q;
  logic [HandleW-1:0] gen_q;
  logic [HandleW-1:0] gen_inc;
  rsp_t               out_q;
  logic               out_valid_q;
  rsp_t               emit_rsp;
  logic               fin_emit;
  logic               emit_any;
  logic               out_free;
  logic               advance;
  logic               accept;
  logic [IRQ_BITS-1:0]     irq_st;
  logic [CHANNEL_BITS-1:0] chan_st;

  assign accept   = req_i.valid && req_i.ready;
  assign req_i.ready = !busy_q;

  // Incoming fields are cut to the stored widths once, at the head of the row.
  assign irq_st  = IRQ_BITS'(req_i.irq_line);
  assign chan_st = CHANNEL_BITS'(req_i.channel_id);

  always_comb begin
    chain_head        = '0;
    chain_head.valid  = accept;
    chain_head.req    = req_e'(req_i.req_type);
    chain_head.irq    = IrqW'(irq_st);
    chain_head.chan   = ChanW'(chan_st);
    chain_head.ok     = req_i.channel_ok;
    chain_head.handle = req_i.sub_handle;
  end

  assign chain[0] = chain_head;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    isr_cell #(
      .CHANNEL_BITS (CHANNEL_BITS),
      .IRQ_BITS     (IRQ_BITS),
      .INDEX        (i)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .advance_i (advance),
      .gen_i     (gen_q[GenBits-1:0]),
      .pkt_i     (chain[i]),
      .pkt_o     (chain[i+1]),
      .emit_o    (cell_emit[i])
    );
  end

  // Only one request is in flight, so at most one cell drives its delivery.
  always_comb begin
    cell_any = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      cell_any = emit_t'(cell_any | cell_emit[i]);
    end
  end

  always_comb begin
    fin_emit = fin_q.valid && ((fin_q.req != REQ_PUB) || fin_q.pend_valid);
    emit_rsp = '0;
    if (fin_emit) begin
      emit_rsp.last = 1'b1;
      unique case (fin_q.req)
        REQ_SUB: begin
          emit_rsp.status     = !fin_q.done;
          emit_rsp.new_handle = fin_q.done ? fin_q.new_handle : '0;
        end
        REQ_UNSUB: emit_rsp.status = !fin_q.done;
        REQ_PUB: begin
          emit_rsp.dest_channel   = fin_q.pend_chan;
          emit_rsp.event_irq      = fin_q.irq;
          emit_rsp.event_sequence = fin_q.pend_seq;
        end
        REQ_COUNT: emit_rsp.match_count = fin_q.count;
        default: ;
      endcase
    end else begin
      emit_rsp.dest_channel   = cell_any.chan;
      emit_rsp.event_irq      = cell_any.irq;
      emit_rsp.event_sequence = cell_any.seq;
    end
  end

  assign emit_any = fin_emit || cell_any.valid;
  assign out_free = !out_valid_q || rsp_o.ready;
  assign advance  = !emit_any || out_free;

  assign gen_inc = gen_q + HandleW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_q  <= '0;
      busy_q <= 1'b0;
      gen_q  <= GenReset;
    end else begin
      if (advance) begin
        fin_q <= chain[ENTRIES];
      end
      if (accept) begin
        busy_q <= 1'b1;
      end else if (fin_q.valid && advance) begin
        busy_q <= 1'b0;
      end
      // The generation moves on only for a subscribe that found a slot.
      if (fin_q.valid && advance && (fin_q.req == REQ_SUB) && fin_q.done) begin
        gen_q <= (gen_inc == '0) ? GenReset : gen_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= emit_any;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && emit_any) begin
      out_q <= emit_rsp;
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.status         = out_q.status;
  assign rsp_o.new_handle     = out_q.new_handle;
  assign rsp_o.match_count    = out_q.match_count;
  assign rsp_o.dest_channel   = out_q.dest_channel;
  assign rsp_o.event_irq      = out_q.event_irq;
  assign rsp_o.event_sequence = out_q.event_sequence;
  assign rsp_o.last           = out_q.last;

endmodule

`default_nettype wire

// File: sv/isr_checker.sv
// Port-level checks for the interrupt subscription router, bound to its top.
// Depends on isr_pkg for the field widths.
`default_nettype none

module isr_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_ready_i,
  input wire logic                        out_valid_i,
  input wire logic                        out_ready_i,
  input wire logic                        out_status_i,
  input wire logic [isr_pkg::HandleW-1:0] out_new_handle_i,
  input wire logic [isr_pkg::CountW-1:0]  out_match_count_i,
  input wire logic [isr_pkg::SeqW-1:0]    out_event_sequence_i,
  input wire logic                        out_last_i
);
  import isr_pkg::*;

  // A pending result stays up until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_event_sequence_i)
      && $stable(out_new_handle_i) && $stable(out_last_i))
    else $error("result changed while stalled");

  // Requests are worked one at a time.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request taken while another is in flight");

  // Only publish deliveries come without the last mark.
  a_delivery_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_last_i |-> !out_status_i && (out_new_handle_i == '0)
      && (out_match_count_i == '0))
    else $error("non-final result that is not a delivery");

  // A handle always carries a nonzero slot tag.
  a_handle_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_new_handle_i != '0) |-> (out_new_handle_i[TagBits-1:0] != '0)
      && !out_status_i)
    else $error("handle without a slot tag");

endmodule

bind interrupt_subscription_router_top isr_checker u_isr_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .in_valid_i           (req_i.valid),
  .in_ready_i           (req_i.ready),
  .out_valid_i          (rsp_o.valid),
  .out_ready_i          (rsp_o.ready),
  .out_status_i         (rsp_o.status),
  .out_new_handle_i     (rsp_o.new_handle),
  .out_match_count_i    (rsp_o.match_count),
  .out_event_sequence_i (rsp_o.event_sequence),
  .out_last_i           (rsp_o.last)
);

`default_nettype wire
